FILE: rtl/core/psu_pkg.sv
// psu_pkg: shared types, codes and constants of the png scanline unfilter
// depends on nothing; used by psu_if, psu_front, psu_back and png_scanline_unfilter

package psu_pkg;

    // default line store depth in bytes
    localparam int MAX_ROW_BYTES_DEF = 8192;

    // width of the row length product and its saturation compare
    localparam int PROD_W = 17;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES  = 2'd2;

    // pixel_bytes code that selects rgb, every other code means rgba
    localparam logic [2:0] PIXEL_BYTES_RGB = 3'd3;

    // filter type codes
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    // configuration register file contents
    typedef struct packed {
        logic [11:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  pixel_bytes;
    } cfg_t;

    // one classified data byte, handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] channel;
        logic [2:0] filt;
        logic       err;
        logic       last;
        logic       upper_ok;
    } uop_t;

endpackage

FILE: rtl/core/psu_if.sv
// psu_if: valid/ready channel interfaces of the png scanline unfilter
// depends on psu_pkg for the configuration port widths

// inflated stream bytes
interface psu_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       image_start;

    modport source (output valid, output stream_byte, output image_start, input ready);
    modport sink   (input valid, input stream_byte, input image_start, output ready);
endinterface

// reconstructed pixel bytes
interface psu_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic [1:0] channel;
    logic       bad_filter;
    logic       image_last;

    modport source (output valid, output pixel_byte, output channel, output bad_filter,
                    output image_last, input ready);
    modport sink   (input valid, input pixel_byte, input channel, input bad_filter,
                    input image_last, output ready);
endinterface

// register writes
interface psu_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [psu_pkg::CFG_IDX_W-1:0]   index;
    logic [psu_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/psu_front.sv
// psu_front: accepts stream bytes, tracks row and column, classifies each byte
// depends on psu_pkg and psu_stream_if; feeds psu_queue

module psu_front #(
    parameter  int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
    localparam int XW            = $clog2(MAX_ROW_BYTES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psu_pkg::cfg_t        cfg,
    psu_stream_if.sink           stream,
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic [XW-1:0]        q_x,
    output psu_pkg::uop_t        q_uop
);
    import psu_pkg::*;

    localparam int CW = $clog2(MAX_ROW_BYTES + 1);
    localparam logic [PROD_W-1:0] MAX_LEN = PROD_W'(MAX_ROW_BYTES);

    logic [CW-1:0]     col_reg, col_next;
    logic [15:0]       row_reg, row_next;
    logic [2:0]        filt_reg, filt_next;
    logic              err_reg, err_next;
    logic [1:0]        mod3_reg, mod3_next;

    logic              bpp3;
    logic [11:0]       w_eff;
    logic [15:0]       h_eff;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] row_len;
    logic [CW-1:0]     col_cur;
    logic [15:0]       row_cur;
    logic [15:0]       row_inc;
    logic              err_cur;
    logic              done;
    logic              is_filter;
    logic              row_end;
    logic              accept;
    logic [XW-1:0]     x;

    // effective configuration
    always_comb
    begin
        bpp3    = (cfg.pixel_bytes == PIXEL_BYTES_RGB);
        w_eff   = (cfg.image_width == 12'd0) ? 12'd1 : cfg.image_width;
        h_eff   = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
        prod    = bpp3 ? ({5'b0, w_eff} + {4'b0, w_eff, 1'b0}) : {3'b0, w_eff, 2'b0};
        row_len = (prod > MAX_LEN) ? MAX_LEN : prod;
    end

    // classify the byte on the channel
    always_comb
    begin
        col_cur   = stream.image_start ? '0 : col_reg;
        row_cur   = stream.image_start ? 16'd0 : row_reg;
        err_cur   = stream.image_start ? 1'b0 : err_reg;
        row_inc   = row_cur + 16'd1;
        done      = (row_cur >= h_eff);
        is_filter = (col_cur == '0);
        x         = XW'(col_cur - CW'(1));
        row_end   = (PROD_W'(col_cur) >= row_len);
    end

    assign stream.ready = q_ready;
    assign accept       = stream.valid && q_ready;

    // data bytes go to the back
    always_comb
    begin
        q_valid        = stream.valid && !done && !is_filter;
        q_x            = x;
        q_uop.data     = stream.stream_byte;
        q_uop.channel  = bpp3 ? mod3_reg : x[1:0];
        q_uop.filt     = filt_reg;
        q_uop.err      = err_cur;
        q_uop.last     = row_end && (row_inc >= h_eff);
        q_uop.upper_ok = (row_cur != 16'd0);
    end

    // row and column bookkeeping
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        filt_next = filt_reg;
        err_next  = err_reg;
        mod3_next = mod3_reg;
        if (accept)
        begin
            col_next = col_cur;
            row_next = row_cur;
            err_next = err_cur;
            if (!done)
            begin
                if (is_filter)
                begin
                    if (stream.stream_byte > {5'b0, FILT_PAETH})
                        err_next = 1'b1;
                    else
                        filt_next = stream.stream_byte[2:0];
                    col_next  = CW'(1);
                    mod3_next = 2'd0;
                end
                else
                begin
                    mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                    if (row_end)
                    begin
                        col_next = '0;
                        row_next = row_inc;
                    end
                    else
                    begin
                        col_next = col_cur + CW'(1);
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= 16'd0;
            filt_reg <= FILT_NONE;
            err_reg  <= 1'b0;
            mod3_reg <= 2'd0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            filt_reg <= filt_next;
            err_reg  <= err_next;
            mod3_reg <= mod3_next;
        end
    end

endmodule

FILE: rtl/core/psu_queue.sv
// psu_queue: small register fifo that decouples front and back
// depends on nothing but its parameters

module psu_queue #(
    parameter int DW    = 16,
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DW-1:0] slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          push, pop;

    assign in_ready  = (count_reg != NW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        case ({push, pop})
            2'b10:   count_next = count_reg + NW'(1);
            2'b01:   count_next = count_reg - NW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_data;
    end

endmodule

FILE: rtl/core/psu_back.sv
// psu_back: line store, filter reconstruction and output register
// depends on psu_pkg and psu_pixel_if; fed by psu_queue

module psu_back #(
    parameter  int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
    localparam int XW            = $clog2(MAX_ROW_BYTES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psu_pkg::cfg_t        cfg,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic [XW-1:0]        q_x,
    input  psu_pkg::uop_t        q_uop,
    psu_pixel_if.source          pixels
);
    import psu_pkg::*;

    logic [7:0]    line_mem [MAX_ROW_BYTES];

    logic          ex_valid_reg, ex_valid_next;
    uop_t          ex_uop_reg;
    logic [XW-1:0] ex_x_reg;
    logic [7:0]    above_reg;
    logic [31:0]   left_reg;
    logic [31:0]   upleft_reg;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;
    logic [1:0]    out_chan_reg;
    logic          out_bad_reg;
    logic          out_last_reg;

    logic          advance;
    logic          pop;
    logic          first;
    logic [1:0]    sel;
    logic [7:0]    a, b, c;
    logic [8:0]    sum_ab;
    logic [7:0]    pred;
    logic [7:0]    v;

    // paeth predictor, distances taken as |b-c|, |a-c| and |a+b-2c|
    function automatic logic [7:0] paeth(input logic [7:0] pa_in, input logic [7:0] pb_in,
                                         input logic [7:0] pc_in);
        logic signed [9:0] da, db, dc;
        logic [9:0]        pa, pb, pc;
        da = $signed({2'b0, pb_in}) - $signed({2'b0, pc_in});
        db = $signed({2'b0, pa_in}) - $signed({2'b0, pc_in});
        dc = $signed({2'b0, pa_in}) + $signed({2'b0, pb_in}) - $signed({1'b0, pc_in, 1'b0});
        pa = da[9] ? 10'(-da) : 10'(da);
        pb = db[9] ? 10'(-db) : 10'(db);
        pc = dc[9] ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc)
            return pa_in;
        else if (pb <= pc)
            return pb_in;
        else
            return pc_in;
    endfunction

    // two stage handshake: exec slot then output register
    assign advance = ex_valid_reg && (!out_valid_reg || pixels.ready);
    assign q_ready = !ex_valid_reg || advance;
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        ex_valid_next = ex_valid_reg;
        if (pop)
            ex_valid_next = 1'b1;
        else if (advance)
            ex_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (pixels.ready)
            out_valid_next = 1'b0;
    end

    // neighbours and reconstruction
    always_comb
    begin
        first  = (ex_x_reg == '0);
        sel    = (cfg.pixel_bytes == PIXEL_BYTES_RGB) ? 2'd2 : 2'd3;
        a      = first ? 8'd0 : left_reg[8*sel +: 8];
        c      = first ? 8'd0 : upleft_reg[8*sel +: 8];
        b      = ex_uop_reg.upper_ok ? above_reg : 8'd0;
        sum_ab = {1'b0, a} + {1'b0, b};
        case (ex_uop_reg.filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = sum_ab[8:1];
            FILT_PAETH: pred = paeth(a, b, c);
            default:    pred = 8'd0;
        endcase
        v = ex_uop_reg.err ? ex_uop_reg.data : ex_uop_reg.data + pred;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ex_valid_reg  <= ex_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, neighbour history and line store
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ex_uop_reg <= q_uop;
            ex_x_reg   <= q_x;
            above_reg  <= line_mem[q_x];
        end
        if (advance)
        begin
            line_mem[ex_x_reg] <= v;
            left_reg     <= first ? {24'd0, v} : {left_reg[23:0], v};
            upleft_reg   <= first ? {24'd0, b} : {upleft_reg[23:0], b};
            out_byte_reg <= v;
            out_chan_reg <= ex_uop_reg.channel;
            out_bad_reg  <= ex_uop_reg.err;
            out_last_reg <= ex_uop_reg.last;
        end
    end

    assign pixels.valid      = out_valid_reg;
    assign pixels.pixel_byte = out_byte_reg;
    assign pixels.channel    = out_chan_reg;
    assign pixels.bad_filter = out_bad_reg;
    assign pixels.image_last = out_last_reg;

endmodule

FILE: rtl/core/png_scanline_unfilter.sv
// png_scanline_unfilter: top level, configuration registers and block wiring
// depends on psu_pkg, psu_if, psu_front, psu_queue and psu_back
// usage
//   stream: one inflated byte per item; the first byte of each row is its
//   filter type, image_start on an item restarts the image at row 0.
//   pixels: one item per data byte, the reconstructed sample with its
//   channel, the sticky bad_filter flag and image_last on the final byte.
//   cfg: register writes (width, height, pixel bytes), always ready, to be
//   issued only while no item is in flight.
// timing
//   one item per cycle while pixels is ready, set by the left-byte feedback of one predictor
//   and one add in the back end; a data byte taken from stream reaches pixels by passing
//   through the queue, the exec slot and the output register in turn.
// reset
//   counters, error and filter clear; the line store is not cleared, the
//   first row of an image never uses it. no clearing pass is needed.
// stalls
//   when pixels is held off, the output register holds, then the exec slot,
//   then the four-entry queue fills and stream.ready drops; filter bytes and
//   bytes beyond the image are taken while the queue has room.

module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    psu_stream_if.sink  stream,
    psu_pixel_if.source pixels,
    psu_cfg_if.sink     cfg
);
    import psu_pkg::*;

    localparam int XW = $clog2(MAX_ROW_BYTES);
    localparam int UW = $bits(uop_t);

    cfg_t          cfg_reg;
    logic          fq_valid, fq_ready;
    logic [XW-1:0] fq_x;
    uop_t          fq_uop;
    logic          qb_valid, qb_ready;
    logic [XW-1:0] qb_x;
    uop_t          qb_uop;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 12'd1;
            cfg_reg.image_height <= 16'd1;
            cfg_reg.pixel_bytes  <= 3'd4;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg.data[11:0];
                CFG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg.data[15:0];
                CFG_PIXEL_BYTES:  cfg_reg.pixel_bytes  <= cfg.data[2:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front: classify
    psu_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .stream  (stream),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_x     (fq_x),
        .q_uop   (fq_uop)
    );

    // decoupling queue
    psu_queue #(
        .DW    (XW + UW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_x, fq_uop}),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  ({qb_x, qb_uop})
    );

    // back: reconstruct
    psu_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_x     (qb_x),
        .q_uop   (qb_uop),
        .pixels  (pixels)
    );

endmodule

FILE: rtl/core/psu_checker.sv
// psu_checker: port level assertions of the png scanline unfilter
// depends on png_scanline_unfilter; attached to it by the bind below

module psu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [1:0] out_chan,
    input logic       out_bad,
    input logic       out_last
);

    // a result waiting to be taken stays offered
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // and its fields do not move
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(out_chan)
                                    && $stable(out_bad) && $stable(out_last))
        else $error("result changed while stalled");

    // the input side only backs up when the output side was stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("input held off without an output stall");

    // nothing comes out straight after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result offered right after reset");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (stream.ready),
    .out_valid (pixels.valid),
    .out_ready (pixels.ready),
    .out_byte  (pixels.pixel_byte),
    .out_chan  (pixels.channel),
    .out_bad   (pixels.bad_filter),
    .out_last  (pixels.image_last)
);
